// ===== rtl/core/srr_pkg.sv =====
// Shared constants, types and helpers of the selective-repeat receiver.
package srr_pkg;

  localparam int unsigned SeqW      = 4;
  localparam int unsigned SeqSpace  = 1 << SeqW;
  localparam int unsigned WinW      = 4;
  localparam int unsigned LenW      = 8;
  localparam int unsigned TagW      = 16;
  localparam int unsigned EntryW    = LenW + TagW;

  localparam logic [WinW-1:0] WinReset = WinW'(4);
  localparam logic [WinW-1:0] WinMax   = WinW'(SeqSpace / 2);

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  // A zero window acts as one; anything above half the sequence space is clamped.
  function automatic logic [WinW-1:0] eff_window(input logic [WinW-1:0] win);
    logic [WinW-1:0] w;
    w = win;
    if (w == '0) begin
      w = WinW'(1);
    end
    if (w > WinMax) begin
      w = WinMax;
    end
    return w;
  endfunction

endpackage

// ===== rtl/core/srr_in_if.sv =====
// Packet channel into the receiver: handshake plus packet fields.
interface srr_in_if;
  logic                         valid;
  logic                         ready;
  logic [srr_pkg::SeqW-1:0]     seq_num;
  logic                         is_data;
  logic                         check_ok;
  logic [srr_pkg::LenW-1:0]     payload_len;
  logic [srr_pkg::TagW-1:0]     payload_tag;

  modport source (output valid, seq_num, is_data, check_ok, payload_len, payload_tag,
                  input ready);
  modport sink   (input valid, seq_num, is_data, check_ok, payload_len, payload_tag,
                  output ready);
endinterface

// ===== rtl/core/srr_out_if.sv =====
// Result channel out of the receiver: handshake plus result fields.
interface srr_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [srr_pkg::SeqW-1:0] out_seq;
  logic [srr_pkg::LenW-1:0] out_len;
  logic [srr_pkg::TagW-1:0] out_tag;
  logic                     last;

  modport source (output valid, kind, out_seq, out_len, out_tag, last, input ready);
  modport sink   (input valid, kind, out_seq, out_len, out_tag, last, output ready);
endinterface

// ===== rtl/core/srr_alu.sv =====
// Shared modular adder with window compare, used for offset and base increment.
module srr_alu (
  input  logic [srr_pkg::SeqW-1:0] a_i,
  input  logic [srr_pkg::SeqW-1:0] b_i,
  input  logic [srr_pkg::WinW-1:0] win_i,
  output logic [srr_pkg::SeqW-1:0] sum_o,
  output logic                     in_win_o
);

  // Wrap-around is implicit in the width of the sequence space.
  assign sum_o    = a_i + b_i;
  assign in_win_o = ({1'b0, sum_o} < {1'b0, win_i});

endmodule

// ===== rtl/core/selective_repeat_receiver.sv =====
// Top level of the selective-repeat receiver: sequencer, mark flags and slot memory.
//
// Packets arrive on in_i and results leave on out_o; each is a valid/ready
// channel and a transfer happens at a rising clock edge with both high. The
// window width is written through cfg_we_i/cfg_wdata_i, which the user must do only
// while the block is idle; the block itself does not enforce this. A packet that
// is not data, has a bad checksum, or arrives after an end of transfer is dropped in
// its accepting cycle and yields no result. A good data packet is latched and then
// acknowledged from the acknowledge state; each in-order slot then drained passes
// through a slot memory read and then a state that presents the result. A single
// adder is shared between the window offset and the base increment. The block
// accepts one packet at a time. Results sit in an output register, so a new packet
// may be taken while the last result still waits; when the receiver stalls, the
// sequencer holds in place until the output register frees up. Reset clears the
// marks, the expected base, the done flag, and sets the window to four; the slot
// memory needs no clearing because a slot is read only after its mark was set.
module selective_repeat_receiver (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [srr_pkg::WinW-1:0] cfg_wdata_i,
  srr_in_if.sink                   in_i,
  srr_out_if.source                out_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StAck  = 2'd1;
  localparam logic [1:0] StRead = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [srr_pkg::SeqW-1:0]      base_q, base_d;
  logic                          done_q, done_d;
  logic [srr_pkg::WinW-1:0]      window_q;
  logic [srr_pkg::SeqSpace-1:0]  mark_q, mark_d;

  // Latched packet fields.
  logic [srr_pkg::SeqW-1:0]      seq_q;
  logic [srr_pkg::LenW-1:0]      len_q;
  logic [srr_pkg::TagW-1:0]      tag_q;
  logic                          pkt_load;

  // Slot memory with a registered read port.
  logic [srr_pkg::EntryW-1:0]    entry_mem [srr_pkg::SeqSpace];
  logic [srr_pkg::EntryW-1:0]    rdata_q;
  logic                          mem_we;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic [1:0]                    kind_q, kind_d;
  logic [srr_pkg::SeqW-1:0]      oseq_q, oseq_d;
  logic [srr_pkg::LenW-1:0]      olen_q, olen_d;
  logic [srr_pkg::TagW-1:0]      otag_q, otag_d;
  logic                          olast_q, olast_d;
  logic                          out_load;
  logic                          out_free;

  // Shared adder.
  logic [srr_pkg::SeqW-1:0]      alu_a, alu_b, alu_sum;
  logic                          alu_in_win;
  logic                          store;
  logic                          next_marked;

  srr_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .win_i    (srr_pkg::eff_window(window_q)),
    .sum_o    (alu_sum),
    .in_win_o (alu_in_win)
  );

  // While acknowledging, the adder forms the offset from the base; while
  // draining, it steps the base on by one.
  assign alu_a = (state_q == StAck) ? seq_q : base_q;
  assign alu_b = (state_q == StAck) ? (srr_pkg::SeqW'(0) - base_q) : srr_pkg::SeqW'(1);

  assign store       = alu_in_win && !mark_q[seq_q];
  assign next_marked = mark_q[alu_sum];
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    done_d      = done_q;
    mark_d      = mark_q;
    pkt_load    = 1'b0;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    kind_d      = kind_q;
    oseq_d      = oseq_q;
    olen_d      = olen_q;
    otag_d      = otag_q;
    olast_d     = olast_q;

    case (state_q)
      StIdle: begin
        if (in_i.valid && !done_q && in_i.is_data && in_i.check_ok) begin
          pkt_load = 1'b1;
          state_d  = StAck;
        end
      end
      StAck: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = srr_pkg::KIND_ACK;
          oseq_d   = seq_q;
          olen_d   = '0;
          otag_d   = '0;
          // The base slot is never held between packets, so a drain follows
          // only when this packet lands exactly on the base.
          olast_d  = !(store && (alu_sum == '0));
          if (store) begin
            mem_we        = 1'b1;
            mark_d[seq_q] = 1'b1;
          end
          state_d = (store && (alu_sum == '0)) ? StRead : StIdle;
        end
      end
      StRead: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          out_load = 1'b1;
          oseq_d   = base_q;
          if (rdata_q[srr_pkg::EntryW-1 -: srr_pkg::LenW] == '0) begin
            kind_d = srr_pkg::KIND_END;
            olen_d = '0;
            otag_d = '0;
            done_d = 1'b1;
          end else begin
            kind_d = srr_pkg::KIND_DELIVER;
            olen_d = rdata_q[srr_pkg::EntryW-1 -: srr_pkg::LenW];
            otag_d = rdata_q[srr_pkg::TagW-1:0];
          end
          olast_d        = !next_marked;
          mark_d[base_q] = 1'b0;
          base_d         = alu_sum;
          state_d        = next_marked ? StRead : StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      base_q      <= '0;
      done_q      <= 1'b0;
      mark_q      <= '0;
      window_q    <= srr_pkg::WinReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      done_q      <= done_d;
      mark_q      <= mark_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_load) begin
      seq_q <= in_i.seq_num;
      len_q <= in_i.payload_len;
      tag_q <= in_i.payload_tag;
    end
    if (out_load) begin
      kind_q  <= kind_d;
      oseq_q  <= oseq_d;
      olen_q  <= olen_d;
      otag_q  <= otag_d;
      olast_q <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[seq_q] <= {len_q, tag_q};
    end
    if (state_q == StRead) begin
      rdata_q <= entry_mem[base_q];
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.kind    = kind_q;
  assign out_o.out_seq = oseq_q;
  assign out_o.out_len = olen_q;
  assign out_o.out_tag = otag_q;
  assign out_o.last    = olast_q;

endmodule
